FILE: src/assert_macros.svh
// Assertion macros shared by the walker RTL.
// Stand-alone header; expands to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SWG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SWG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SWG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SWG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: src/swg_pkg.sv
// Shared constants, register codes, sequencer states and the MAC command
// type of the strided grid walker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swg_pkg;

   localparam int FIELD_BITS         = 16;
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int IDX_BITS           = 3 * FIELD_BITS;
   localparam int NUM_AXES           = 3;
   localparam int SETUP_BITS         = 64;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int RANK_BITS          = 2;
   localparam int MUL_A_BITS         = FIELD_BITS;
   localparam int MUL_B_BITS         = 2 * FIELD_BITS;

   localparam int SIZE_LSB   = 48;
   localparam int START_LSB  = 32;
   localparam int STOP_LSB   = 16;
   localparam int STRIDE_LSB = 0;

   // size 2, start 0, stop 1, stride 1
   localparam logic [SETUP_BITS-1:0] AXIS_SETUP_RESET = 64'h0002_0000_0001_0001;
   localparam logic [RANK_BITS-1:0]  RANK_RESET       = 2'd3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_AXIS_I       = 3'd0,
      CSR_AXIS_J       = 3'd1,
      CSR_AXIS_K       = 3'd2,
      CSR_GRID_RANK    = 3'd3,
      CSR_PARTIAL_STEP = 3'd4,
      CSR_CELL_MODE    = 3'd5
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP,
      ST_FLAG,
      ST_IDX,
      ST_REM,
      ST_N_SS,
      ST_N_JS,
      ST_N_I,
      ST_N_K,
      ST_C_SS,
      ST_C_JS,
      ST_C_I,
      ST_C_K,
      ST_DONE
   } walk_state_type;

   typedef struct packed {
      logic                  en;
      logic                  clr;
      logic [MUL_A_BITS-1:0] a;
      logic [MUL_B_BITS-1:0] b;
   } mac_op_type;

   // usable width of one packed setup field
   function automatic int field_width(input int coord_bits);
      return (coord_bits < FIELD_BITS) ? coord_bits : FIELD_BITS;
   endfunction

endpackage

`default_nettype wire

FILE: src/swg_rem.sv
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// Depends on swg_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

module swg_rem #(
   parameter int COORD_BITS = swg_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [swg_pkg::field_width(COORD_BITS)+1:0] dividend,
   input  wire logic [swg_pkg::field_width(COORD_BITS)-1:0] divisor,
   output logic               done,
   output logic [swg_pkg::field_width(COORD_BITS)-1:0] remainder
);

   localparam int FW = swg_pkg::field_width(COORD_BITS);
   localparam int PW = FW + 2;
   localparam int CW = $clog2(PW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [PW-1:0] dvd_ff;
   logic [FW-1:0] dvs_ff;
   logic [FW-1:0] rem_ff;

   logic [FW:0]   trial;
   logic [FW:0]   diff;
   logic          fits;

   assign trial = {rem_ff, dvd_ff[PW-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(PW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[PW-2:0], 1'b0};
         rem_ff <= fits ? diff[FW-1:0] : trial[FW-1:0];
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: src/swg_mac.sv
// Shared multiply-accumulate unit for the linear index sums.
// Registered accumulator; depends on swg_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module swg_mac (
   input  wire logic                         clock,
   input  wire swg_pkg::mac_op_type          op,
   output logic [swg_pkg::IDX_BITS-1:0]      acc
);

   logic [swg_pkg::IDX_BITS-1:0] prod;
   logic [swg_pkg::IDX_BITS-1:0] acc_ff;

   // 16 x 32 product, truncated to the index width
   assign prod = op.a * op.b;

   always_ff @(posedge clock) begin
      if (op.en) begin
         acc_ff <= (op.clr ? '0 : acc_ff) + prod;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

FILE: src/strided_grid_subsample_index_walker.sv
// Strided grid walker top: config registers, walk sequencer, remainder and MAC units.
// Each request takes a step that may give no result and return to idle; otherwise it runs
// flag, index (with the remainder unit for each axis whose position needs it), node MAC
// steps, cell MAC steps in cell mode and done; one request at a time.
// Synchronous active-high reset: registers to defaults, walk inactive, positions zero.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module strided_grid_subsample_index_walker #(
   parameter int COORD_BITS = swg_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_restart,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [swg_pkg::IDX_BITS-1:0]             rsp_node_index,
   output logic [swg_pkg::IDX_BITS-1:0]             rsp_cell_index,
   output logic                                     rsp_cell_valid,
   output logic [swg_pkg::IDX_BITS-1:0]             rsp_output_slot,
   output logic                                     rsp_last,
   input  wire logic                                csr_wr_en,
   input  wire logic [swg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [swg_pkg::SETUP_BITS-1:0]      csr_wdata
);

   localparam int FW = (COORD_BITS < swg_pkg::FIELD_BITS) ? COORD_BITS : swg_pkg::FIELD_BITS;
   localparam int PW = FW + 2;
   localparam int NA = swg_pkg::NUM_AXES;
   localparam int IB = swg_pkg::IDX_BITS;
   localparam int MA = swg_pkg::MUL_A_BITS;
   localparam int MB = swg_pkg::MUL_B_BITS;
   localparam int RB = swg_pkg::RANK_BITS;
   localparam logic [1:0] LAST_AXIS = 2'(NA - 1);

   // configuration
   logic [swg_pkg::SETUP_BITS-1:0] axis_setup_ff [NA];
   logic [RB-1:0]                  rank_ff;
   logic                           partial_ff;
   logic                           cell_mode_ff;

   // decoded axes (combinational from config, captured at accept)
   logic [RB-1:0] rank_eff;
   logic [FW-1:0] dec_size   [NA];
   logic [FW-1:0] dec_start  [NA];
   logic [FW-1:0] dec_stride [NA];
   logic [FW:0]   dec_stop   [NA];
   logic [PW-1:0] dec_end    [NA];
   logic [FW:0]   dec_lim    [NA];
   logic [PW-1:0] dec_limx   [NA];

   logic [FW-1:0] size_ff   [NA];
   logic [FW-1:0] start_ff  [NA];
   logic [FW-1:0] stride_ff [NA];
   logic [FW:0]   stop_ff   [NA];
   logic [PW-1:0] end_ff    [NA];
   logic [FW:0]   lim_ff    [NA];
   logic [PW-1:0] limx_ff   [NA];

   // walk state
   swg_pkg::walk_state_type state_ff, state_in;
   logic          walk_active_ff;
   logic [PW-1:0] pos_ff [NA];
   logic [IB-1:0] slot_ff;
   logic          restart_ff;
   logic          last_ff;
   logic          further_ff;
   logic [1:0]    ax_ff;
   logic [FW-1:0] idx_ff [NA];
   logic [MB-1:0] m1_ff;
   logic [IB-1:0] node_ff;

   logic          rsp_valid_ff;
   logic [IB-1:0] rsp_node_ff;
   logic [IB-1:0] rsp_cell_ff;
   logic          rsp_cell_valid_ff;
   logic [IB-1:0] rsp_slot_ff;
   logic          rsp_last_ff;

   // step logic
   logic [PW-1:0] clamp_start [NA];
   logic [PW-1:0] raw         [NA];
   logic [PW-1:0] clamp_raw   [NA];
   logic [PW-1:0] pos_adv     [NA];
   logic [NA-1:0] more;
   logic [NA-1:0] no_room;
   logic          moved;
   logic          empty_walk;

   // index logic
   logic [PW-1:0] idx_pos;
   logic          idx_special;
   logic          idx_below;
   logic          need_rem;
   logic [FW-1:0] idx_direct;

   logic          req_fire;
   logic          rsp_free;
   logic          rsp_load;
   logic          rem_start;
   logic          rem_done;
   logic [FW-1:0] rem_value;
   swg_pkg::mac_op_type mac_op;
   logic [IB-1:0] mac_acc;

   assign req_fire   = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rank_eff   = (rank_ff == '0) ? RB'(1) : rank_ff;
   assign empty_walk = |no_room;

   for (genvar g = 0; g < NA; g++) begin : g_axis
      logic          act;
      logic [FW-1:0] size_raw;
      logic [FW-1:0] stop_raw;
      logic [FW-1:0] stride_raw;
      logic [FW-1:0] step_add;

      assign act        = RB'(g) < rank_eff;
      assign size_raw   = axis_setup_ff[g][swg_pkg::SIZE_LSB +: FW];
      assign dec_start[g] = axis_setup_ff[g][swg_pkg::START_LSB +: FW];
      assign stop_raw   = axis_setup_ff[g][swg_pkg::STOP_LSB +: FW];
      assign stride_raw = axis_setup_ff[g][swg_pkg::STRIDE_LSB +: FW];

      assign dec_stride[g] = (stride_raw == '0) ? FW'(1) : stride_raw;
      assign dec_size[g]   = (size_raw == '0 || !act) ? FW'(1) : size_raw;
      // stop at or below start wraps by one axis size
      assign dec_stop[g]   = (stop_raw <= dec_start[g])
                             ? ((FW+1)'(stop_raw) + (FW+1)'(dec_size[g]))
                             : (FW+1)'(stop_raw);
      assign step_add      = !act ? '0 : (partial_ff ? dec_stride[g] : FW'(1));
      assign dec_end[g]    = PW'(dec_stop[g]) + PW'(step_add);
      assign dec_lim[g]    = (FW+1)'(dec_start[g]) + (FW+1)'(dec_size[g]);
      assign dec_limx[g]   = PW'(dec_lim[g]) + PW'(dec_stride[g]);

      assign clamp_start[g] = (start_ff[g] > stop_ff[g]) ? PW'(stop_ff[g]) : PW'(start_ff[g]);
      assign raw[g]         = pos_ff[g] + PW'(stride_ff[g]);
      assign more[g]        = raw[g] < end_ff[g];
      assign clamp_raw[g]   = (raw[g] > PW'(stop_ff[g])) ? PW'(stop_ff[g]) : raw[g];
      assign no_room[g]     = PW'(start_ff[g]) >= end_ff[g];
   end

   // axis i changes fastest; a carry reloads the lower axes at start, clamped to stop
   always_comb begin
      pos_adv = clamp_start;
      moved   = 1'b1;
      if (more[0]) begin
         pos_adv[0] = clamp_raw[0];
         pos_adv[1] = pos_ff[1];
         pos_adv[2] = pos_ff[2];
      end else if (more[1]) begin
         pos_adv[1] = clamp_raw[1];
         pos_adv[2] = pos_ff[2];
      end else if (more[2]) begin
         pos_adv[2] = clamp_raw[2];
      end else begin
         moved = 1'b0;
      end
   end

   // the step that crosses start + size maps back to start
   assign idx_pos     = pos_ff[ax_ff];
   assign idx_special = (idx_pos <= limx_ff[ax_ff]) && (PW'(lim_ff[ax_ff]) <= idx_pos);
   assign idx_below   = idx_pos < PW'(size_ff[ax_ff]);
   assign need_rem    = !idx_special && !idx_below;
   assign idx_direct  = idx_special ? start_ff[ax_ff] : idx_pos[FW-1:0];

   swg_rem #(
      .COORD_BITS (COORD_BITS)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (idx_pos),
      .divisor   (size_ff[ax_ff]),
      .done      (rem_done),
      .remainder (rem_value)
   );

   swg_mac u_mac (
      .clock (clock),
      .op    (mac_op),
      .acc   (mac_acc)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         swg_pkg::ST_IDLE: begin
            if (req_fire) state_in = swg_pkg::ST_STEP;
         end
         swg_pkg::ST_STEP: begin
            if (restart_ff) begin
               state_in = empty_walk ? swg_pkg::ST_IDLE : swg_pkg::ST_FLAG;
            end else begin
               state_in = (walk_active_ff && moved) ? swg_pkg::ST_FLAG : swg_pkg::ST_IDLE;
            end
         end
         swg_pkg::ST_FLAG: state_in = swg_pkg::ST_IDX;
         swg_pkg::ST_IDX: begin
            if (need_rem) state_in = swg_pkg::ST_REM;
            else if (ax_ff == LAST_AXIS) state_in = swg_pkg::ST_N_SS;
         end
         swg_pkg::ST_REM: begin
            if (rem_done) begin
               state_in = (ax_ff == LAST_AXIS) ? swg_pkg::ST_N_SS : swg_pkg::ST_IDX;
            end
         end
         swg_pkg::ST_N_SS: state_in = swg_pkg::ST_N_JS;
         swg_pkg::ST_N_JS: state_in = swg_pkg::ST_N_I;
         swg_pkg::ST_N_I:  state_in = swg_pkg::ST_N_K;
         swg_pkg::ST_N_K:  state_in = swg_pkg::ST_C_SS;
         swg_pkg::ST_C_SS: state_in = cell_mode_ff ? swg_pkg::ST_C_JS : swg_pkg::ST_DONE;
         swg_pkg::ST_C_JS: state_in = swg_pkg::ST_C_I;
         swg_pkg::ST_C_I:  state_in = swg_pkg::ST_C_K;
         swg_pkg::ST_C_K:  state_in = swg_pkg::ST_DONE;
         swg_pkg::ST_DONE: begin
            if (rsp_free) state_in = swg_pkg::ST_IDLE;
         end
         default: state_in = swg_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer; MAC schedule builds k*(sj*si) + j*si + i
   always_comb begin
      req_stall  = state_ff != swg_pkg::ST_IDLE;
      rem_start  = 1'b0;
      rsp_load   = 1'b0;
      mac_op     = '0;
      unique case (state_ff)
         swg_pkg::ST_IDX: rem_start = need_rem;
         swg_pkg::ST_N_SS: begin
            mac_op = '{en: 1'b1, clr: 1'b1, a: MA'(size_ff[0]), b: MB'(size_ff[1])};
         end
         swg_pkg::ST_N_JS: begin
            mac_op = '{en: 1'b1, clr: 1'b1, a: MA'(idx_ff[1]), b: MB'(size_ff[0])};
         end
         swg_pkg::ST_N_I, swg_pkg::ST_C_I: begin
            mac_op = '{en: 1'b1, clr: 1'b0, a: MA'(idx_ff[0]), b: MB'(1)};
         end
         swg_pkg::ST_N_K, swg_pkg::ST_C_K: begin
            mac_op = '{en: 1'b1, clr: 1'b0, a: MA'(idx_ff[2]), b: m1_ff};
         end
         swg_pkg::ST_C_SS: begin
            mac_op = '{en: cell_mode_ff, clr: 1'b1,
                       a: MA'(size_ff[0] - FW'(1)), b: MB'(size_ff[1] - FW'(1))};
         end
         swg_pkg::ST_C_JS: begin
            mac_op = '{en: 1'b1, clr: 1'b1, a: MA'(idx_ff[1]), b: MB'(size_ff[0] - FW'(1))};
         end
         swg_pkg::ST_DONE: rsp_load = rsp_free;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= swg_pkg::ST_IDLE;
         walk_active_ff <= 1'b0;
         slot_ff        <= '0;
         ax_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
         rank_ff        <= swg_pkg::RANK_RESET;
         partial_ff     <= 1'b0;
         cell_mode_ff   <= 1'b0;
         for (int a = 0; a < NA; a++) begin
            axis_setup_ff[a] <= swg_pkg::AXIS_SETUP_RESET;
            pos_ff[a]        <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            unique case (swg_pkg::csr_reg_type'(csr_index))
               swg_pkg::CSR_AXIS_I:       axis_setup_ff[0] <= csr_wdata;
               swg_pkg::CSR_AXIS_J:       axis_setup_ff[1] <= csr_wdata;
               swg_pkg::CSR_AXIS_K:       axis_setup_ff[2] <= csr_wdata;
               swg_pkg::CSR_GRID_RANK:    rank_ff          <= csr_wdata[RB-1:0];
               swg_pkg::CSR_PARTIAL_STEP: partial_ff       <= csr_wdata[0];
               swg_pkg::CSR_CELL_MODE:    cell_mode_ff     <= csr_wdata[0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && !rsp_load) rsp_valid_ff <= 1'b0;

         case (state_ff)
            swg_pkg::ST_STEP: begin
               if (restart_ff) begin
                  if (empty_walk) begin
                     walk_active_ff <= 1'b0;
                  end else begin
                     pos_ff         <= clamp_start;
                     slot_ff        <= '0;
                     walk_active_ff <= 1'b1;
                  end
               end else if (walk_active_ff) begin
                  pos_ff <= pos_adv;
                  if (moved) slot_ff <= slot_ff + 1'b1;
                  else walk_active_ff <= 1'b0;
               end
            end
            swg_pkg::ST_FLAG: ax_ff <= '0;
            swg_pkg::ST_IDX: begin
               if (!need_rem) ax_ff <= ax_ff + 1'b1;
            end
            swg_pkg::ST_REM: begin
               if (rem_done) ax_ff <= ax_ff + 1'b1;
            end
            swg_pkg::ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (last_ff) walk_active_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         restart_ff <= req_restart;
         size_ff    <= dec_size;
         start_ff   <= dec_start;
         stride_ff  <= dec_stride;
         stop_ff    <= dec_stop;
         end_ff     <= dec_end;
         lim_ff     <= dec_lim;
         limx_ff    <= dec_limx;
      end
      if (state_ff == swg_pkg::ST_FLAG) begin
         last_ff    <= ~|more;
         further_ff <= &more;
      end
      if (state_ff == swg_pkg::ST_IDX && !need_rem) idx_ff[ax_ff] <= idx_direct;
      if (state_ff == swg_pkg::ST_REM && rem_done) idx_ff[ax_ff] <= rem_value;
      if (state_ff == swg_pkg::ST_N_JS || state_ff == swg_pkg::ST_C_JS) begin
         m1_ff <= mac_acc[MB-1:0];
      end
      if (state_ff == swg_pkg::ST_C_SS) node_ff <= mac_acc;
      if (rsp_load) begin
         rsp_node_ff       <= node_ff;
         rsp_cell_ff       <= cell_mode_ff ? mac_acc : '0;
         rsp_cell_valid_ff <= cell_mode_ff && further_ff;
         rsp_slot_ff       <= slot_ff;
         rsp_last_ff       <= last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_index  = rsp_node_ff;
   assign rsp_cell_index  = rsp_cell_ff;
   assign rsp_cell_valid  = rsp_cell_valid_ff;
   assign rsp_output_slot = rsp_slot_ff;
   assign rsp_last        = rsp_last_ff;

   `SWG_ASSERT_IMPLY(a_rem_done_in_wait, clock, reset, rem_done, state_ff == swg_pkg::ST_REM, "remainder finished outside its wait state")
   `SWG_ASSERT_NEXT(a_last_ends_walk, clock, reset, rsp_load && last_ff, !walk_active_ff, "walk still active after its last request")
   `SWG_ASSERT_IMPLY(a_pos_in_range, clock, reset, walk_active_ff && state_ff == swg_pkg::ST_IDLE, pos_ff[0] <= PW'(stop_ff[0]), "axis i position beyond stop")

endmodule

`default_nettype wire

FILE: sim/tb_strided_grid_subsample_index_walker.sv
// Self-checking bench for the strided grid walker: directed and random walks
// scored against a behavioral model of the walk. Depends on swg_pkg and the RTL.
`timescale 1ns / 1ps

module tb_strided_grid_subsample_index_walker;

   localparam int          COORD_BITS   = swg_pkg::COORD_BITS_DEFAULT;
   localparam logic [31:0] COORD_MASK   = (32'd1 << COORD_BITS) - 32'd1;
   localparam int          DRAIN_CYCLES = 100;
   localparam int          CYCLE_LIMIT  = 600000;
   localparam int          RAND_PHASES  = 40;
   localparam int          PHASE_ITEMS  = 15;

   typedef struct packed {
      logic [swg_pkg::IDX_BITS-1:0] node_index;
      logic [swg_pkg::IDX_BITS-1:0] cell_index;
      logic                         cell_valid;
      logic [swg_pkg::IDX_BITS-1:0] output_slot;
      logic                         last_point;
   } walk_point_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_restart = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [swg_pkg::IDX_BITS-1:0]       rsp_node_index;
   logic [swg_pkg::IDX_BITS-1:0]       rsp_cell_index;
   logic                               rsp_cell_valid;
   logic [swg_pkg::IDX_BITS-1:0]       rsp_output_slot;
   logic                               rsp_last;
   logic                               csr_wr_en = 1'b0;
   logic [swg_pkg::CSR_INDEX_BITS-1:0] csr_index = swg_pkg::CSR_AXIS_I;
   logic [swg_pkg::SETUP_BITS-1:0]     csr_wdata = '0;

   // model copy of the registers and walk state
   logic [swg_pkg::SETUP_BITS-1:0] cfg_axis [3];
   logic [swg_pkg::RANK_BITS-1:0]  cfg_rank;
   bit                             cfg_partial;
   bit                             cfg_cell;
   logic [31:0]                    walk_pos [3];
   logic [swg_pkg::IDX_BITS-1:0]   slot_cnt;
   bit                             walk_on;

   bit                    walk_cmds [$];
   walk_point_type        expected_points [$];
   walk_point_type        predicted;
   bit                    req_fire = 1'b0;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   int                    mismatch_count = 0;
   int                    cycle_count = 0;

   strided_grid_subsample_index_walker #(.COORD_BITS(COORD_BITS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_node_index  (rsp_node_index),
      .rsp_cell_index  (rsp_cell_index),
      .rsp_cell_valid  (rsp_cell_valid),
      .rsp_output_slot (rsp_output_slot),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // One walk request: returns 1 and the expected point when it yields one.
   function automatic bit advance_walk(input bit restart, output walk_point_type res);
      logic [31:0] sz [3];
      logic [31:0] st [3];
      logic [31:0] sp [3];
      logic [31:0] sd [3];
      logic [31:0] ax_end [3];
      logic [31:0] raw;
      logic [31:0] lim;
      logic [63:0] idx [3];
      logic [63:0] si;
      logic [63:0] sj;
      logic [63:0] acc;
      int          act_axes;
      bit          moved;
      bit          is_last;
      bit          further;
      res = '0;
      act_axes = (cfg_rank == 2'd0) ? 1 : int'(cfg_rank);
      for (int a = 0; a < swg_pkg::NUM_AXES; a++) begin
         sz[a] = {16'h0, cfg_axis[a][swg_pkg::SIZE_LSB +: swg_pkg::FIELD_BITS]} & COORD_MASK;
         st[a] = {16'h0, cfg_axis[a][swg_pkg::START_LSB +: swg_pkg::FIELD_BITS]} & COORD_MASK;
         sp[a] = {16'h0, cfg_axis[a][swg_pkg::STOP_LSB +: swg_pkg::FIELD_BITS]} & COORD_MASK;
         sd[a] = {16'h0, cfg_axis[a][swg_pkg::STRIDE_LSB +: swg_pkg::FIELD_BITS]} & COORD_MASK;
         if (sd[a] == 0) sd[a] = 1;
         if (sz[a] == 0 || a >= act_axes) sz[a] = 1;
         if (sp[a] <= st[a]) sp[a] = sp[a] + sz[a];
         if (a >= act_axes) ax_end[a] = sp[a];
         else ax_end[a] = sp[a] + (cfg_partial ? sd[a] : 32'd1);
      end

      if (restart) begin
         for (int a = 0; a < swg_pkg::NUM_AXES; a++) begin
            if (st[a] >= ax_end[a]) begin
               walk_on = 1'b0;
               return 1'b0;
            end
         end
         for (int a = 0; a < swg_pkg::NUM_AXES; a++)
            walk_pos[a] = (st[a] > sp[a]) ? sp[a] : st[a];
         slot_cnt = '0;
         walk_on = 1'b1;
      end else begin
         if (!walk_on) return 1'b0;
         moved = 1'b0;
         // odometer: first axis that can still step moves, lower ones rewind
         for (int a = 0; a < swg_pkg::NUM_AXES; a++) begin
            if (!moved) begin
               raw = walk_pos[a] + sd[a];
               if (raw < ax_end[a]) begin
                  walk_pos[a] = (raw > sp[a]) ? sp[a] : raw;
                  moved = 1'b1;
               end else begin
                  walk_pos[a] = (st[a] > sp[a]) ? sp[a] : st[a];
               end
            end
         end
         if (!moved) begin
            walk_on = 1'b0;
            return 1'b0;
         end
         slot_cnt = slot_cnt + 1'b1;
      end

      is_last = 1'b1;
      further = 1'b1;
      for (int a = 0; a < swg_pkg::NUM_AXES; a++) begin
         if (walk_pos[a] + sd[a] < ax_end[a]) is_last = 1'b0;
         else further = 1'b0;
         // crossing start + size folds back onto start
         lim = st[a] + sz[a];
         if (walk_pos[a] <= lim + sd[a] && lim <= walk_pos[a]) idx[a] = {32'h0, st[a]};
         else idx[a] = {32'h0, walk_pos[a] % sz[a]};
      end
      si = {32'h0, sz[0]};
      sj = {32'h0, sz[1]};
      acc = idx[2] * sj * si + idx[1] * si + idx[0];
      res.node_index = acc[swg_pkg::IDX_BITS-1:0];
      if (cfg_cell) begin
         acc = idx[2] * (sj - 64'd1) * (si - 64'd1) + idx[1] * (si - 64'd1) + idx[0];
         res.cell_index = acc[swg_pkg::IDX_BITS-1:0];
         res.cell_valid = further;
      end
      res.output_slot = slot_cnt;
      res.last_point = is_last;
      if (is_last) walk_on = 1'b0;
      return 1'b1;
   endfunction

   // request acceptance and prediction
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         req_fire = 1'b1;
         if (advance_walk(req_restart, predicted)) expected_points.push_back(predicted);
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!req_valid || req_fire) begin
         if (walk_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_restart <= walk_cmds.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_fire = 1'b0;
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // result monitor
   always @(posedge clock) begin : monitor
      walk_point_type exp_pt;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $error("unexpected result: node_index %0h", rsp_node_index);
            mismatch_count++;
         end else begin
            exp_pt = expected_points.pop_front();
            if (rsp_node_index !== exp_pt.node_index) begin
               $error("node_index: expected %0h, got %0h", exp_pt.node_index, rsp_node_index);
               mismatch_count++;
            end
            if (rsp_cell_index !== exp_pt.cell_index) begin
               $error("cell_index: expected %0h, got %0h", exp_pt.cell_index, rsp_cell_index);
               mismatch_count++;
            end
            if (rsp_cell_valid !== exp_pt.cell_valid) begin
               $error("cell_valid: expected %0b, got %0b", exp_pt.cell_valid, rsp_cell_valid);
               mismatch_count++;
            end
            if (rsp_output_slot !== exp_pt.output_slot) begin
               $error("output_slot: expected %0h, got %0h", exp_pt.output_slot,
                      rsp_output_slot);
               mismatch_count++;
            end
            if (rsp_last !== exp_pt.last_point) begin
               $error("last: expected %0b, got %0b", exp_pt.last_point, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   task automatic csr_write(input swg_pkg::csr_reg_type idx,
                            input logic [swg_pkg::SETUP_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         swg_pkg::CSR_AXIS_I:       cfg_axis[0] = data;
         swg_pkg::CSR_AXIS_J:       cfg_axis[1] = data;
         swg_pkg::CSR_AXIS_K:       cfg_axis[2] = data;
         swg_pkg::CSR_GRID_RANK:    cfg_rank = data[swg_pkg::RANK_BITS-1:0];
         swg_pkg::CSR_PARTIAL_STEP: cfg_partial = data[0];
         swg_pkg::CSR_CELL_MODE:    cfg_cell = data[0];
         default: ;
      endcase
   endtask

   // mode registers get random upper bits; only the low bits matter
   task automatic program_walker(input logic [swg_pkg::SETUP_BITS-1:0] ai, aj, ak,
                                 input logic [swg_pkg::RANK_BITS-1:0] rank,
                                 input bit partial, input bit cell_en);
      logic [swg_pkg::SETUP_BITS-1:0] d;
      csr_write(swg_pkg::CSR_AXIS_I, ai);
      csr_write(swg_pkg::CSR_AXIS_J, aj);
      csr_write(swg_pkg::CSR_AXIS_K, ak);
      d = {$urandom, $urandom};
      d[swg_pkg::RANK_BITS-1:0] = rank;
      csr_write(swg_pkg::CSR_GRID_RANK, d);
      d = {$urandom, $urandom};
      d[0] = partial;
      csr_write(swg_pkg::CSR_PARTIAL_STEP, d);
      d = {$urandom, $urandom};
      d[0] = cell_en;
      csr_write(swg_pkg::CSR_CELL_MODE, d);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      while (walk_cmds.size() != 0 || req_valid || expected_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] extreme_field();
      case ($urandom_range(4))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'hFFFF;
         3: return 16'hFFFE;
         default: return 16'($urandom);
      endcase
   endfunction

   // kind 0: raw random bits, 1: boundary values, else short walks
   function automatic logic [swg_pkg::SETUP_BITS-1:0] gen_axis(input int kind, input bit minor);
      logic [15:0] sz;
      logic [15:0] st;
      logic [15:0] sp;
      logic [15:0] sd;
      if (kind == 0) return {$urandom, $urandom};
      if (kind == 1) begin
         sz = extreme_field();
         st = extreme_field();
         sp = extreme_field();
         sd = extreme_field();
      end else begin
         sz = 16'($urandom_range(minor ? 3 : 6));
         st = 16'($urandom_range(minor ? 3 : 7));
         sp = 16'($urandom_range(minor ? 3 : 7));
         sd = 16'($urandom_range(3));
      end
      return {sz, st, sp, sd};
   endfunction

   initial begin : stimulus
      int n;
      int k;
      int kind;
      for (int a = 0; a < swg_pkg::NUM_AXES; a++) begin
         cfg_axis[a] = swg_pkg::AXIS_SETUP_RESET;
         walk_pos[a] = '0;
      end
      cfg_rank = swg_pkg::RANK_RESET;
      cfg_partial = 1'b0;
      cfg_cell = 1'b0;
      slot_cnt = '0;
      walk_on = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: 2x2x2 walk, with advances before and after it
      walk_cmds.push_back(1'b0);
      walk_cmds.push_back(1'b1);
      repeat (8) walk_cmds.push_back(1'b0);
      wait_idle();

      // widest fields on one active axis, all-ones on an inactive one
      program_walker(64'hFFFF_FFFF_0000_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                     2'd1, 1'b1, 1'b1);
      walk_cmds.push_back(1'b1);
      repeat (2) walk_cmds.push_back(1'b0);
      wait_idle();

      // start equal to size on every axis: indices fold to start or zero and wrap 48 bits
      program_walker(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 1'b1, 1'b1);
      walk_cmds.push_back(1'b1);
      repeat (8) walk_cmds.push_back(1'b0);
      wait_idle();

      // zero size, zero stride, rank zero
      program_walker(64'h0, 64'h0, 64'h0, 2'd0, 1'b0, 1'b1);
      walk_cmds.push_back(1'b1);
      repeat (2) walk_cmds.push_back(1'b0);
      wait_idle();

      // inactive axis with stop below start: empty walk
      program_walker(64'h0003_0000_0002_0001, 64'h0002_0000_0001_0001,
                     64'h0007_0005_0003_0001, 2'd2, 1'b0, 1'b0);
      walk_cmds.push_back(1'b1);
      walk_cmds.push_back(1'b0);
      wait_idle();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         kind = $urandom_range(9);
         program_walker(gen_axis(kind, 1'b0), gen_axis(kind, 1'b1), gen_axis(kind, 1'b1),
                        2'($urandom_range(3)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
         // a few advances first carry the previous walk into the new setup
         n = $urandom_range(3);
         repeat (n) walk_cmds.push_back(1'b0);
         while (n < PHASE_ITEMS) begin
            walk_cmds.push_back(1'b1);
            k = $urandom_range(40);
            repeat (k) walk_cmds.push_back(1'b0);
            n = n + k + 1;
         end
         wait_idle();
      end

      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
